// ----- sv/aes_pkg.sv -----
package aes_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [7:0]         byte_t;

    typedef enum logic {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } cfg_index_t;

    localparam byte_t GF_REDUCE = 8'h1B;

    function automatic byte_t sbox(input byte_t v);
        byte_t r;
        case (v)
            8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
            8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
            8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
            8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
            8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
            8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
            8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
            8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
            8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
            8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
            8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
            8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
            8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
            8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
            8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
            8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
            8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
            8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
            8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
            8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
            8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
            8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
            8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
            8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
            8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
            8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
            8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
            8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
            8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
            8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
            8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
            8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
            8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
            8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
            8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
            8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
            8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
            8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
            8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
            8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
            8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
            8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
            8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
            8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
            8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
            8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
            8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
            8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
            8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
            8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
            8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
            8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
            8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
            8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
            8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
            8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
            8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
            8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
            8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
            8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
            8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
            8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
            8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
            8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // rounds beyond the table get 0
    function automatic byte_t rcon(input logic [3:0] round);
        byte_t r;
        case (round)
            4'd1:  r = 8'h01;
            4'd2:  r = 8'h02;
            4'd3:  r = 8'h04;
            4'd4:  r = 8'h08;
            4'd5:  r = 8'h10;
            4'd6:  r = 8'h20;
            4'd7:  r = 8'h40;
            4'd8:  r = 8'h80;
            4'd9:  r = 8'h1b;
            4'd10: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // byte n of a block sits in bits [127-8n -: 8]
    function automatic byte_t get_byte(input block_t b, input int n);
        return b[BLOCK_W-1-8*n -: 8];
    endfunction

    function automatic byte_t gf_double(input byte_t v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : 8'h00);
    endfunction

endpackage

// ----- sv/aes_round_cell.sv -----
// One round of the cipher chain: expands its own round key from the
// previous one and transforms the state, registered at the output.
module aes_round_cell #(
    parameter logic [3:0] ROUND = 4'd1,
    parameter bit         LAST  = 1'b0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  aes_pkg::block_t in_state,
    input  aes_pkg::block_t in_key,
    output logic          out_valid,
    output aes_pkg::block_t out_state,
    output aes_pkg::block_t out_key
);
    import aes_pkg::*;

    byte_t  s  [16];
    byte_t  sr [16];
    byte_t  mc [16];
    byte_t  k  [16];
    byte_t  t  [4];
    block_t state_next;
    block_t key_next;
    logic   valid_reg;
    block_t state_reg;
    block_t key_reg;

    always_comb begin
        for (int n = 0; n < 16; n++) begin
            s[n] = sbox(get_byte(in_state, n));
            k[n] = get_byte(in_key, n);
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sr[4*c+r] = s[4*((c+r)%4)+r];
            end
        end
        for (int c = 0; c < 4; c++) begin
            mc[4*c+0] = gf_double(sr[4*c]) ^ gf_double(sr[4*c+1]) ^ sr[4*c+1]
                        ^ sr[4*c+2] ^ sr[4*c+3];
            mc[4*c+1] = sr[4*c] ^ gf_double(sr[4*c+1]) ^ gf_double(sr[4*c+2])
                        ^ sr[4*c+2] ^ sr[4*c+3];
            mc[4*c+2] = sr[4*c] ^ sr[4*c+1] ^ gf_double(sr[4*c+2])
                        ^ gf_double(sr[4*c+3]) ^ sr[4*c+3];
            mc[4*c+3] = gf_double(sr[4*c]) ^ sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2]
                        ^ gf_double(sr[4*c+3]);
        end
        t[0] = sbox(k[13]) ^ rcon(ROUND);
        t[1] = sbox(k[14]);
        t[2] = sbox(k[15]);
        t[3] = sbox(k[12]);
        for (int n = 0; n < 4; n++) begin
            k[n] = k[n] ^ t[n];
        end
        for (int n = 4; n < 16; n++) begin
            k[n] = k[n] ^ k[n-4];
        end
        for (int n = 0; n < 16; n++) begin
            key_next[BLOCK_W-1-8*n -: 8]   = k[n];
            state_next[BLOCK_W-1-8*n -: 8] = (LAST ? sr[n] : mc[n]) ^ k[n];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_key   = key_reg;

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(adv) && $past(aresetn) |-> $stable(valid_reg) && $stable(state_reg))
        else $error("round cell changed while stalled");
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(adv) && $past(in_valid) && $past(aresetn) |-> valid_reg)
        else $error("round cell dropped a block");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(adv) && !$past(in_valid) && $past(aresetn) |-> !valid_reg)
        else $error("round cell invented a block");
`endif
endmodule

// ----- sv/aes128_block_encrypt_unit.sv -----
// Pipeline: the whitening register loads at the accepting edge, then one
// registered cell per round; the last cell is the output register.
// Throughput: one block per cycle unless the output stalls; the ten round
// cells form a chain that advances as a whole whenever the output stage is
// empty or being taken.
// Reset: aresetn synchronous, active low; clears all valid bits and both
// key registers to zero.
module aes128_block_encrypt_unit #(
    parameter int ROUND_COUNT = 10
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // plain_high [63:0], plain_low [127:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // cipher_high [63:0], cipher_low [127:64]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data
);
    import aes_pkg::*;

    logic [HALF_W-1:0] key_high_reg;
    logic [HALF_W-1:0] key_low_reg;
    logic   adv;
    logic   v   [ROUND_COUNT+1];
    block_t st  [ROUND_COUNT+1];
    block_t ky  [ROUND_COUNT+1];
    logic   v0_reg;
    block_t st0_reg;
    block_t ky0_reg;
    block_t key_w;
    block_t plain_w;

    assign cfg_ready = 1'b1;
    assign key_w   = {key_high_reg, key_low_reg};
    assign plain_w = {s_tdata[63:0], s_tdata[127:64]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole chain moves when the last stage is free
    assign adv      = !v[ROUND_COUNT] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st0_reg <= plain_w ^ key_w;
            ky0_reg <= key_w;
        end
    end

    assign v[0]  = v0_reg;
    assign st[0] = st0_reg;
    assign ky[0] = ky0_reg;

    for (genvar g = 1; g <= ROUND_COUNT; g++) begin : g_round
        aes_round_cell #(
            .ROUND (4'(g)),
            .LAST  (g == ROUND_COUNT)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (v[g-1]),
            .in_state  (st[g-1]),
            .in_key    (ky[g-1]),
            .out_valid (v[g]),
            .out_state (st[g]),
            .out_key   (ky[g])
        );
    end

    assign m_tvalid = v[ROUND_COUNT];
    assign m_tdata  = {st[ROUND_COUNT][63:0], st[ROUND_COUNT][127:64]};

`ifndef ASSERT_OFF
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");
    a_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result lost under stall");
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");
`endif
endmodule
